### sv/calendar_time_converter_defines.svh
// Assertion macros for the calendar time converter checker.
// Depends on a signal named clock and a signal named reset in the using scope.
`ifndef CALENDAR_TIME_CONVERTER_DEFINES_SVH
`define CALENDAR_TIME_CONVERTER_DEFINES_SVH

// Checked only outside reset
`define CTC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked during reset too
`define CTC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/ctc_pkg.sv
// Shared types, constants and tables of the calendar time converter.
// No dependencies.
`timescale 1ns / 1ps

package ctc_pkg;

   typedef enum logic [1:0] {
      FUNC_TO_SEC   = 2'd0,
      FUNC_TO_DATE  = 2'd1,
      FUNC_ADD_ZONE = 2'd2,
      FUNC_SUB_ZONE = 2'd3
   } func_type;

   // Per-stage control that travels with the data
   typedef struct packed {
      logic     valid;
      func_type func;
   } ctl_type;

   // Time-of-day fields collected while splitting seconds
   typedef struct packed {
      logic [31:0] secs;
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
   } clock_type;

   localparam logic [16:0] ZONE_RESET = 17'd28800;
   localparam logic [12:0] EPOCH_YEAR = 13'd1970;
   // leap years in [1, 1969]
   localparam logic [11:0] LEAPS_BEFORE_EPOCH = 12'd477;
   // reciprocal multipliers: x/100, x/60, x/3, x/365
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam logic [31:0] RECIP_60  = 32'h8888_8889;
   localparam logic [31:0] RECIP_3   = 32'hAAAA_AAAB;
   localparam logic [15:0] RECIP_365 = 16'd45965;

   // Days before the first of month idx+1 in a common year
   function automatic logic [8:0] days_before(input logic [3:0] idx);
      logic [8:0] r;
      unique case (idx)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         4'd11:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

### sv/ctc_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// No dependencies.
`timescale 1ns / 1ps

interface ctc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic [31:0] epoch_seconds;

   modport source (output valid, func, year, month, day, hour, minute, second,
                   epoch_seconds, input ready);
   modport sink   (input valid, func, year, month, day, hour, minute, second,
                   epoch_seconds, output ready);
endinterface

interface ctc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds_out;
   logic [11:0] year_out;
   logic [3:0]  month_out;
   logic [4:0]  day_out;
   logic [4:0]  hour_out;
   logic [5:0]  minute_out;
   logic [5:0]  second_out;

   modport source (output valid, epoch_seconds_out, year_out, month_out, day_out,
                   hour_out, minute_out, second_out, input ready);
   modport sink   (input valid, epoch_seconds_out, year_out, month_out, day_out,
                   hour_out, minute_out, second_out, output ready);
endinterface

### sv/calendar_time_converter.sv
// Calendar time converter: date-time to epoch seconds and back.
// Depends on ctc_pkg, ctc_channels, ctc_date2sec and ctc_sec2date.
//
// Usage:
//   req_ch carries func and the input date-time or epoch seconds; rsp_ch
//   returns one result per request. csr_wr_en/csr_wr_data load the signed
//   17-bit zone offset (reset 28800) used by func 2 (add) and 3 (subtract).
// Timing:
//   13-stage pipeline. One request enters per cycle while rsp_ch is not
//   stalled; every stage is registered and all stages advance together, so
//   the throughput is one item per cycle while rsp_ch does not stall.
// Reset:
//   synchronous; empties the pipeline and loads the reset zone offset.
// Stall:
//   while rsp_ch holds a result that is not taken, the whole pipeline
//   freezes and req_ch.ready is low; nothing is dropped or repeated.
`timescale 1ns / 1ps

module calendar_time_converter import ctc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ctc_req_if.sink     req_ch,
   ctc_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);

   logic        advance;
   logic [16:0] zone_ff, zone_in;
   ctl_type     ctl_in, ctl_mid, ctl_out;
   logic [31:0] secs_mid, epoch_mid;
   clock_type   tm_out;

   // zone offset register
   assign zone_in = csr_wr_en ? csr_wr_data : zone_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZONE_RESET;
      end else begin
         zone_ff <= zone_in;
      end
   end

   // pipeline moves when the output stage is empty or being taken
   assign advance      = !ctl_out.valid || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign ctl_in.valid = req_ch.valid;
   assign ctl_in.func  = func_type'(req_ch.func);

   ctc_date2sec u_date2sec (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctl_i    (ctl_in),
      .year_i   (req_ch.year),
      .month_i  (req_ch.month),
      .day_i    (req_ch.day),
      .hour_i   (req_ch.hour),
      .minute_i (req_ch.minute),
      .second_i (req_ch.second),
      .epoch_i  (req_ch.epoch_seconds),
      .ctl_o    (ctl_mid),
      .secs_o   (secs_mid),
      .epoch_o  (epoch_mid)
   );

   ctc_sec2date u_sec2date (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .zone_i  (zone_ff),
      .ctl_i   (ctl_mid),
      .secs_i  (secs_mid),
      .epoch_i (epoch_mid),
      .ctl_o   (ctl_out),
      .time_o  (tm_out),
      .year_o  (rsp_ch.year_out),
      .month_o (rsp_ch.month_out),
      .day_o   (rsp_ch.day_out)
   );

   assign rsp_ch.valid             = ctl_out.valid;
   assign rsp_ch.epoch_seconds_out = tm_out.secs;
   assign rsp_ch.hour_out          = tm_out.hour;
   assign rsp_ch.minute_out        = tm_out.min;
   assign rsp_ch.second_out        = tm_out.sec;

endmodule

### sv/ctc_date2sec.sv
// Stages 1-5: date-time fields to seconds since the epoch.
// Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_date2sec import ctc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  ctl_type     ctl_i,
   input  logic [11:0] year_i,
   input  logic [3:0]  month_i,
   input  logic [4:0]  day_i,
   input  logic [4:0]  hour_i,
   input  logic [5:0]  minute_i,
   input  logic [5:0]  second_i,
   input  logic [31:0] epoch_i,
   output ctl_type     ctl_o,
   output logic [31:0] secs_o,
   output logic [31:0] epoch_o
);

   ctl_type     ctl_ff   [1:5];
   logic [31:0] epoch_ff [1:5];
   logic [4:0]  hour_ff  [1:2];
   logic [5:0]  min_ff   [1:3];
   logic [5:0]  sec_ff   [1:4];

   logic [12:0] yr1_in, yr1_ff, n1;
   logic [3:0]  mon1_in, mon1_ff;
   logic [4:0]  day1_in, day1_ff;
   logic [25:0] py, pn;
   logic [6:0]  qy1_in, qy1_ff, qn1_in, qn1_ff;

   logic [13:0]        qy100;
   logic [12:0]        n2;
   logic               leap2;
   logic [11:0]        lu2, lp2;
   logic signed [13:0] ydiff2;
   logic [31:0]        days2_in, days2_ff;
   logic [31:0]        hrs3_in, hrs3_ff, mins4_in, mins4_ff, secs5_in, secs5_ff;

   // stage 1: clamp month and day, fold month, divide years by 100
   always_comb begin
      mon1_in = (month_i == 4'd0) ? 4'd1 : month_i;
      day1_in = (day_i == 5'd0) ? 5'd1 : day_i;
      yr1_in  = {1'b0, year_i};
      if (mon1_in > 4'd12) begin
         mon1_in = mon1_in - 4'd12;
         yr1_in  = yr1_in + 13'd1;
      end
      n1     = yr1_in - 13'd1;
      py     = 26'(yr1_in) * 26'(RECIP_100);
      pn     = 26'(n1) * 26'(RECIP_100);
      qy1_in = py[25:19];
      qn1_in = pn[25:19];
   end

   // stage 2: day count from leap rule, month table and year offset
   always_comb begin
      qy100  = 14'(qy1_ff) * 14'd100;
      leap2  = (yr1_ff[1:0] == 2'd0) &&
               ((14'(yr1_ff) != qy100) || (qy1_ff[1:0] == 2'd0));
      n2     = yr1_ff - 13'd1;
      lu2    = 12'(n2[12:2]) - 12'(qn1_ff) + 12'(qn1_ff[6:2]);
      lp2    = (yr1_ff > EPOCH_YEAR) ? (lu2 - LEAPS_BEFORE_EPOCH) : 12'd0;
      ydiff2 = $signed({1'b0, yr1_ff}) - $signed({1'b0, EPOCH_YEAR});
      days2_in = {{18{ydiff2[13]}}, ydiff2} * 32'd365 + 32'(lp2)
               + 32'(leap2 && (mon1_ff >= 4'd3))
               + 32'(days_before(mon1_ff - 4'd1)) + 32'(day1_ff) - 32'd1;
   end

   // stages 3-5: weighted sum, one multiply per stage
   assign hrs3_in  = days2_ff * 32'd24 + 32'(hour_ff[2]);
   assign mins4_in = hrs3_ff * 32'd60 + 32'(min_ff[3]);
   assign secs5_in = mins4_ff * 32'd60 + 32'(sec_ff[4]);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 5; i++) ctl_ff[i].valid <= 1'b0;
      end else if (advance) begin
         ctl_ff[1] <= ctl_i;
         for (int i = 2; i <= 5; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   // data
   always_ff @(posedge clock) begin
      if (advance) begin
         epoch_ff[1]    <= epoch_i;
         for (int i = 2; i <= 5; i++) begin
            epoch_ff[i]    <= epoch_ff[i-1];
         end
         hour_ff[1] <= hour_i;
         hour_ff[2] <= hour_ff[1];
         min_ff[1]  <= minute_i;
         for (int i = 2; i <= 3; i++) min_ff[i] <= min_ff[i-1];
         sec_ff[1]  <= second_i;
         for (int i = 2; i <= 4; i++) sec_ff[i] <= sec_ff[i-1];
         yr1_ff   <= yr1_in;
         mon1_ff  <= mon1_in;
         day1_ff  <= day1_in;
         qy1_ff   <= qy1_in;
         qn1_ff   <= qn1_in;
         days2_ff <= days2_in;
         hrs3_ff  <= hrs3_in;
         mins4_ff <= mins4_in;
         secs5_ff <= secs5_in;
      end
   end

   assign ctl_o   = ctl_ff[5];
   assign secs_o  = secs5_ff;
   assign epoch_o = epoch_ff[5];

endmodule

### sv/ctc_sec2date.sv
// Stages 6-13: zone shift, then seconds to date-time by reciprocal division
// and a one-step year correction. Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_sec2date import ctc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [16:0] zone_i,
   input  ctl_type     ctl_i,
   input  logic [31:0] secs_i,
   input  logic [31:0] epoch_i,
   output ctl_type     ctl_o,
   output clock_type   time_o,
   output logic [11:0] year_o,
   output logic [3:0]  month_o,
   output logic [4:0]  day_o
);

   ctl_type   ctl_ff [6:13];
   clock_type tm_ff  [6:13];
   clock_type tm6_in;
   clock_type tm_in  [7:13];

   logic [31:0] zone_ext;
   logic [63:0] p7, p8;
   logic [49:0] p9;
   logic [31:0] p10;
   logic [26:0] q1_ff, q1b_ff;
   logic [20:0] q2_ff, q2b_ff;
   logic [15:0] d_ff [9:11];
   logic [7:0]  est10_ff;
   logic [11:0] yr11_in, yr11_ff, nm11;
   logic [16:0] start11_in, start11_ff;
   logic [8:0]  len11_in, len11_ff;
   logic [11:0] yr12_in, yr12_ff;
   logic [8:0]  doy12_in, doy12_ff;
   logic        leap12_in, leap12_ff;
   logic [11:0] yr13_in, yr13_ff;
   logic [3:0]  mon13_in, mon13_ff;
   logic [4:0]  dom13_in, dom13_ff;
   logic [8:0]  mstart;

   assign zone_ext = {{15{zone_i[16]}}, zone_i};

   // stage 6: pick the seconds to split
   always_comb begin
      tm6_in = '0;
      unique case (ctl_i.func)
         FUNC_TO_SEC:   tm6_in.secs = secs_i;
         FUNC_TO_DATE:  tm6_in.secs = epoch_i;
         FUNC_ADD_ZONE: tm6_in.secs = secs_i + zone_ext;
         FUNC_SUB_ZONE: tm6_in.secs = secs_i - zone_ext;
      endcase
   end

   // stages 7-10: seconds, minutes, hours, days
   assign p7 = 64'(tm_ff[6].secs) * 64'(RECIP_60);
   assign p8 = 64'(q1_ff) * 64'(RECIP_60);
   assign p9 = 50'(q2_ff[20:3]) * 50'(RECIP_3);
   assign p10 = 32'(d_ff[9]) * 32'(RECIP_365);

   always_comb begin
      tm_in[7]      = tm_ff[6];
      tm_in[8]      = tm_ff[7];
      tm_in[8].sec  = 6'(tm_ff[7].secs - 32'(q1_ff) * 32'd60);
      tm_in[9]      = tm_ff[8];
      tm_in[9].min  = 6'(q1b_ff - 27'(q2_ff) * 27'd60);
      tm_in[10]     = tm_ff[9];
      tm_in[10].hour = 5'(q2b_ff - 21'(d_ff[9]) * 21'd24);
      for (int i = 11; i <= 13; i++) tm_in[i] = tm_ff[i-1];
      // date-to-seconds results carry no time of day
      if (ctl_ff[12].func == FUNC_TO_SEC) begin
         tm_in[13].sec  = 6'd0;
         tm_in[13].min  = 6'd0;
         tm_in[13].hour = 5'd0;
      end
   end

   // stage 11: start day of the estimated year
   always_comb begin
      yr11_in    = 12'd1970 + 12'(est10_ff);
      nm11       = yr11_in - 12'd1;
      start11_in = 17'(est10_ff) * 17'd365 + 17'(nm11[11:2]) - 17'd492
                 - 17'(nm11 >= 12'd2100);
      len11_in   = ((nm11[1:0] == 2'd0) && (nm11 != 12'd2100)) ? 9'd366 : 9'd365;
   end

   // stage 12: estimate may be one year late
   always_comb begin
      if ({1'b0, d_ff[11]} < start11_ff) begin
         yr12_in  = yr11_ff - 12'd1;
         doy12_in = 9'(17'(d_ff[11]) + 17'(len11_ff) - start11_ff);
      end else begin
         yr12_in  = yr11_ff;
         doy12_in = 9'(17'(d_ff[11]) - start11_ff);
      end
      leap12_in = (yr12_in[1:0] == 2'd0) && (yr12_in != 12'd2100);
   end

   // stage 13: month by parallel compare against month starts
   always_comb begin
      mon13_in = 4'd1;
      dom13_in = 5'(doy12_ff + 9'd1);
      mstart   = 9'd0;
      for (int i = 0; i < 12; i++) begin
         mstart = days_before(4'(i)) + ((leap12_ff && i >= 2) ? 9'd1 : 9'd0);
         if (doy12_ff >= mstart) begin
            mon13_in = 4'(i + 1);
            dom13_in = 5'(doy12_ff - mstart + 9'd1);
         end
      end
      yr13_in = yr12_ff;
      if (ctl_ff[12].func == FUNC_TO_SEC) begin
         yr13_in  = 12'd0;
         mon13_in = 4'd0;
         dom13_in = 5'd0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 6; i <= 13; i++) ctl_ff[i].valid <= 1'b0;
      end else if (advance) begin
         ctl_ff[6] <= ctl_i;
         for (int i = 7; i <= 13; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   // data
   always_ff @(posedge clock) begin
      if (advance) begin
         tm_ff[6] <= tm6_in;
         for (int i = 7; i <= 13; i++) tm_ff[i] <= tm_in[i];
         q1_ff      <= p7[63:37];
         q1b_ff     <= q1_ff;
         q2_ff      <= p8[57:37];
         q2b_ff     <= q2_ff;
         d_ff[9]    <= p9[48:33];
         d_ff[10]   <= d_ff[9];
         d_ff[11]   <= d_ff[10];
         est10_ff   <= p10[31:24];
         yr11_ff    <= yr11_in;
         start11_ff <= start11_in;
         len11_ff   <= len11_in;
         yr12_ff    <= yr12_in;
         doy12_ff   <= doy12_in;
         leap12_ff  <= leap12_in;
         yr13_ff    <= yr13_in;
         mon13_ff   <= mon13_in;
         dom13_ff   <= dom13_in;
      end
   end

   assign ctl_o   = ctl_ff[13];
   assign time_o  = tm_ff[13];
   assign year_o  = yr13_ff;
   assign month_o = mon13_ff;
   assign day_o   = dom13_ff;

endmodule

### sv/ctc_checker.sv
// Port-level assertions for the calendar time converter, bound to the top.
// Depends on calendar_time_converter_defines.svh and calendar_time_converter.
`timescale 1ns / 1ps
`include "calendar_time_converter_defines.svh"

module ctc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_epoch,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day
);

   // pipeline is empty after reset
   `CTC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // request side follows the output stage exactly
   `CTC_ASSERT(a_ready_follows, req_ready == (!rsp_valid || rsp_ready), "ready mismatch")

   // stalled result holds
   `CTC_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_epoch), "stalled result changed")

   // a date is either fully present or cleared for func 0
   `CTC_ASSERT(a_date_shape, rsp_valid |-> ((rsp_month == 4'd0) == (rsp_day == 5'd0)), "month and day disagree")

endmodule

bind calendar_time_converter ctc_checker u_ctc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_epoch (rsp_ch.epoch_seconds_out),
   .rsp_month (rsp_ch.month_out),
   .rsp_day   (rsp_ch.day_out)
);
